FILE: rtl/ptmw_pkg.sv
// Shared types, constants and microprogram of the page table map walker.
`timescale 1ns / 1ps
`default_nettype none

package ptmw_pkg;

  // Default sizes; the entry count of one table is fixed by the radix layout
  localparam int POOL_TABLES_DEF   = 64;
  localparam int ROOT_TABLES_DEF   = 4;
  localparam int ENTRIES_PER_LEVEL = 512;
  localparam int LEVEL_BITS        = 9;
  localparam int FRAME_W           = 40;
  localparam int VPAGE_W           = 36;
  localparam int ENTRY_W           = 64;

  // Flags of an intermediate entry: present, writable, user
  localparam logic [11:0] TABLE_FLAGS = 12'h007;
  localparam logic [1:0]  LAST_LEVEL  = 2'd3;

  // Command word
  typedef struct packed {
    logic [1:0]          root_slot;
    logic [VPAGE_W-1:0]  virt_page;
    logic [FRAME_W-1:0]  phys_frame;
    logic [ENTRY_W-1:0]  leaf_flags;
  } map_req_t;

  // Result word
  typedef struct packed {
    logic                status;
    logic [ENTRY_W-1:0]  leaf_entry;
    logic [1:0]          tables_added;
    logic [5:0]          leaf_table_slot;
  } map_rsp_t;

  // Datapath actions
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_READ,
    OP_DESCEND,
    OP_ALLOC,
    OP_LEAF,
    OP_FAIL
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLEAR_LEFT,
    C_NO_START,
    C_NOT_PRESENT,
    C_FOREIGN,
    C_MORE,
    C_NO_ROOM
  } cond_t;

  // Program steps
  typedef enum logic [3:0] {
    S_CLEAR = 4'd0,
    S_IDLE  = 4'd1,
    S_READ  = 4'd2,
    S_TEST  = 4'd3,
    S_DESC  = 4'd4,
    S_LOOP  = 4'd5,
    S_CHK   = 4'd6,
    S_ACHK  = 4'd7,
    S_ALLOC = 4'd8,
    S_LEAF  = 4'd9,
    S_FAIL  = 4'd10
  } step_t;

  // One control word: action, jump condition, jump target (else next step)
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Status from the datapath that the jump conditions test
  typedef struct packed {
    logic start;
    logic clear_left;
    logic present;
    logic foreign;
    logic last_level;
    logic no_room;
  } dp_flags_t;

  // Microprogram ROM
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_CLEAR: w = '{op: OP_CLEAR,   cond: C_CLEAR_LEFT,  target: S_CLEAR};
      S_IDLE:  w = '{op: OP_ACCEPT,  cond: C_NO_START,    target: S_IDLE};
      S_READ:  w = '{op: OP_READ,    cond: C_NEVER,       target: S_READ};
      S_TEST:  w = '{op: OP_NOP,     cond: C_NOT_PRESENT, target: S_CHK};
      S_DESC:  w = '{op: OP_DESCEND, cond: C_FOREIGN,     target: S_FAIL};
      S_LOOP:  w = '{op: OP_NOP,     cond: C_MORE,        target: S_READ};
      S_CHK:   w = '{op: OP_NOP,     cond: C_NO_ROOM,     target: S_FAIL};
      S_ACHK:  w = '{op: OP_NOP,     cond: C_ALWAYS,      target: S_ACHK};
      S_ALLOC: w = '{op: OP_ALLOC,   cond: C_ALWAYS,      target: S_ACHK};
      S_LEAF:  w = '{op: OP_LEAF,    cond: C_ALWAYS,      target: S_IDLE};
      S_FAIL:  w = '{op: OP_FAIL,    cond: C_ALWAYS,      target: S_IDLE};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,      target: S_IDLE};
    endcase
    return w;
  endfunction

  // Table index for a level: bits 47:39, 38:30, 29:21, 20:12 of the address
  function automatic logic [LEVEL_BITS-1:0] level_index(input logic [VPAGE_W-1:0] vpage,
                                                         input logic [1:0] level);
    logic [LEVEL_BITS-1:0] idx;
    case (level)
      2'd0:    idx = vpage[35:27];
      2'd1:    idx = vpage[26:18];
      2'd2:    idx = vpage[17:9];
      default: idx = vpage[8:0];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ptmw_sequencer.sv
// Step counter and microprogram sequencer of the page table map walker.
`timescale 1ns / 1ps
`default_nettype none

module ptmw_sequencer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ptmw_pkg::dp_flags_t flags,
  output ptmw_pkg::op_t            op,
  output logic                     busy
);

  ptmw_pkg::step_t  step;
  ptmw_pkg::step_t  step_next;
  ptmw_pkg::uword_t uw;
  logic             taken;

  // Fetch the control word of the current step
  assign uw = ptmw_pkg::ucode(step);

  // Jump condition and next step
  always_comb begin
    case (uw.cond)
      ptmw_pkg::C_NEVER:       taken = 1'b0;
      ptmw_pkg::C_ALWAYS:      taken = 1'b1;
      ptmw_pkg::C_CLEAR_LEFT:  taken = flags.clear_left;
      ptmw_pkg::C_NO_START:    taken = !flags.start;
      ptmw_pkg::C_NOT_PRESENT: taken = !flags.present;
      ptmw_pkg::C_FOREIGN:     taken = flags.foreign;
      ptmw_pkg::C_MORE:        taken = !flags.last_level;
      ptmw_pkg::C_NO_ROOM:     taken = flags.no_room;
      default:                 taken = 1'b1;
    endcase
    // The allocation check jumps to the leaf once the last level is reached
    if (step == ptmw_pkg::S_ACHK) begin
      step_next = flags.last_level ? ptmw_pkg::S_LEAF : ptmw_pkg::S_ALLOC;
    end else if (taken) begin
      step_next = uw.target;
    end else begin
      step_next = ptmw_pkg::step_t'(step + 4'd1);
    end
  end

  // Outputs to the datapath and the command port
  always_comb begin
    op   = uw.op;
    busy = (step != ptmw_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ptmw_pkg::S_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  // Commands are only taken from the idle step
  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    (step == ptmw_pkg::S_CLEAR) |-> busy)
    else $error("busy low while clearing the table store");

  // A result step always returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    (step == ptmw_pkg::S_LEAF || step == ptmw_pkg::S_FAIL) |=> (step == ptmw_pkg::S_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

`default_nettype wire

FILE: rtl/ptmw_datapath.sv
// Walk datapath: table store, walk registers, slot allocator and result word.
`timescale 1ns / 1ps
`default_nettype none

module ptmw_datapath #(
  parameter int POOL_TABLES = ptmw_pkg::POOL_TABLES_DEF,
  parameter int ROOT_TABLES = ptmw_pkg::ROOT_TABLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ptmw_pkg::op_t                  op,
  input  wire logic                           start,
  input  wire ptmw_pkg::map_req_t             cmd,
  input  wire logic                           cfg_we,
  input  wire logic [ptmw_pkg::FRAME_W-1:0]   cfg_data,
  output ptmw_pkg::dp_flags_t                 flags,
  output logic                                done,
  output ptmw_pkg::map_rsp_t                  result
);

  localparam int DEPTH = POOL_TABLES * ptmw_pkg::ENTRIES_PER_LEVEL;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(POOL_TABLES);
  localparam int FW    = $clog2(POOL_TABLES + 1);

  // Table store
  logic [ptmw_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [ptmw_pkg::ENTRY_W-1:0] rdata;
  logic [ptmw_pkg::ENTRY_W-1:0] wdata;
  logic [AW-1:0]                addr;
  logic                         we;

  // Walk registers
  ptmw_pkg::map_req_t            req;
  logic [ptmw_pkg::FRAME_W-1:0]  base;
  logic [SW-1:0]                 cur;
  logic [1:0]                    level;
  logic [1:0]                    added;
  logic [FW-1:0]                 free;
  logic [AW-1:0]                 cnt;

  logic [ptmw_pkg::FRAME_W-1:0]  off;
  logic [ptmw_pkg::FRAME_W-1:0]  slot_frame;
  logic [ptmw_pkg::ENTRY_W-1:0]  leaf;
  logic [FW:0]                   need_total;
  logic [SW+5:0]                 cur_wide;

  // Pointer offset into the pool and room check
  assign off        = rdata[51:12] - base;
  assign slot_frame = base + ptmw_pkg::FRAME_W'(free);
  assign need_total = {1'b0, free} + (FW+1)'(ptmw_pkg::LAST_LEVEL - level);
  assign leaf       = {12'b0, req.phys_frame, 12'b0} | 64'd1 | req.leaf_flags;
  assign cur_wide   = {6'b0, cur};

  always_comb begin
    flags.start      = start;
    flags.clear_left = (cnt != AW'(DEPTH - 1));
    flags.present    = rdata[0];
    flags.foreign    = (off >= ptmw_pkg::FRAME_W'(POOL_TABLES));
    flags.last_level = (level == ptmw_pkg::LAST_LEVEL);
    flags.no_room    = (need_total > (FW+1)'(POOL_TABLES));
  end

  // Memory address and write word
  always_comb begin
    addr  = {cur, ptmw_pkg::level_index(req.virt_page, level)};
    wdata = '0;
    we    = 1'b0;
    case (op)
      ptmw_pkg::OP_CLEAR: begin
        addr = cnt;
        we   = 1'b1;
      end
      ptmw_pkg::OP_ALLOC: begin
        wdata = {12'b0, slot_frame, ptmw_pkg::TABLE_FLAGS};
        we    = 1'b1;
      end
      ptmw_pkg::OP_LEAF: begin
        wdata = leaf;
        we    = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Single port store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (op == ptmw_pkg::OP_READ) begin
      rdata <= mem[addr];
    end
  end

  // Command word and walk pointer
  always_ff @(posedge clk) begin
    case (op)
      ptmw_pkg::OP_ACCEPT: begin
        if (start) begin
          req <= cmd;
          cur <= SW'(cmd.root_slot);
        end
      end
      ptmw_pkg::OP_DESCEND: cur <= off[SW-1:0];
      ptmw_pkg::OP_ALLOC:   cur <= free[SW-1:0];
      default:              cur <= cur;
    endcase
  end

  // Control registers: level, allocator, clear counter, config
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
      added <= 2'd0;
      free  <= FW'(ROOT_TABLES);
      cnt   <= '0;
      base  <= '0;
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      case (op)
        ptmw_pkg::OP_CLEAR: cnt <= cnt + AW'(1);
        ptmw_pkg::OP_ACCEPT: begin
          level <= 2'd0;
          added <= 2'd0;
        end
        ptmw_pkg::OP_DESCEND: level <= level + 2'd1;
        ptmw_pkg::OP_ALLOC: begin
          level <= level + 2'd1;
          added <= added + 2'd1;
          free  <= free + FW'(1);
        end
        default: level <= level;
      endcase
    end
  end

  // Result word, shown for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == ptmw_pkg::OP_LEAF) || (op == ptmw_pkg::OP_FAIL);
    end
    if (op == ptmw_pkg::OP_LEAF) begin
      result.status          <= 1'b0;
      result.leaf_entry      <= leaf;
      result.tables_added    <= added;
      result.leaf_table_slot <= cur_wide[5:0];
    end else if (op == ptmw_pkg::OP_FAIL) begin
      result <= '{status: 1'b1, default: '0};
    end
  end

  // Allocation only when the room check has passed
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    (op == ptmw_pkg::OP_ALLOC) |-> (free < FW'(POOL_TABLES)))
    else $error("table slot taken beyond the pool");

  // The bump counter never passes the pool size
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (free <= FW'(POOL_TABLES)) || (free == FW'(ROOT_TABLES)))
    else $error("free slot counter out of range");

  // Leaf writes happen only at the last level
  a_leaf_level: assert property (@(posedge clk) disable iff (rst)
    (op == ptmw_pkg::OP_LEAF) |-> (level == ptmw_pkg::LAST_LEVEL))
    else $error("leaf entry written above the last level");

  // A strobe always follows a leaf write or a refusal
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(op) == ptmw_pkg::OP_LEAF || $past(op) == ptmw_pkg::OP_FAIL))
    else $error("result strobe without a finished walk");

endmodule

`default_nettype wire

FILE: rtl/page_table_map_walker.sv
// Top level of the four-level page table map walker.
//
// Command channel: cmd is taken at a rising edge with start high and busy
// low. Each command maps one 4 KiB page in a pool of 512-entry tables,
// adding intermediate tables from a bump allocator as needed.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall, so nothing is held back.
// Configuration: cfg_we writes cfg_data (frame of pool slot zero) at once;
// write it only while the block is idle.
// Walk steps: each present level costs a table read, a test, a descent and
// a loop step on the single store port; each new table costs a check and a
// write. busy falls in the cycle that shows done, so the next command can
// be taken at the edge ending it.
// Reset: the table store is swept to zero one entry a cycle, all
// POOL_TABLES * 512 entries; busy stays high until the sweep ends.
`timescale 1ns / 1ps
`default_nettype none

module page_table_map_walker #(
  parameter int POOL_TABLES = ptmw_pkg::POOL_TABLES_DEF,
  parameter int ROOT_TABLES = ptmw_pkg::ROOT_TABLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire ptmw_pkg::map_req_t             cmd,
  output logic                                done,
  output ptmw_pkg::map_rsp_t                  result,
  input  wire logic                           cfg_we,
  input  wire logic [ptmw_pkg::FRAME_W-1:0]   cfg_data
);

  ptmw_pkg::op_t       op;
  ptmw_pkg::dp_flags_t flags;

  // Microprogram sequencer
  ptmw_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  // Table store and walk datapath
  ptmw_datapath #(
    .POOL_TABLES (POOL_TABLES),
    .ROOT_TABLES (ROOT_TABLES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .start    (start),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .flags    (flags),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: tb/page_table_map_walker_tb.sv
// Self-checking testbench for the four-level page table map walker.
`timescale 1ns / 1ps

module page_table_map_walker_tb;

  localparam int POOL = ptmw_pkg::POOL_TABLES_DEF;
  localparam int ROOTS = ptmw_pkg::ROOT_TABLES_DEF;
  localparam int LAST_DEPTH = int'(ptmw_pkg::LAST_LEVEL);
  localparam int RAND_PER_PHASE = 188;
  localparam int LIMIT_CYCLES = 400000;
  localparam int KNOWN_CAP = 512;

  // Result status codes
  localparam logic MAP_OK      = 1'b0;
  localparam logic MAP_REFUSED = 1'b1;

  localparam logic [ptmw_pkg::ENTRY_W-1:0] ENTRY_PRESENT = 64'h1;
  localparam ptmw_pkg::map_rsp_t REFUSED_RSP = '{status: MAP_REFUSED, leaf_entry: '0,
                                                 tables_added: '0, leaf_table_slot: '0};

  // One row of the directed table
  typedef struct {
    logic                         set_base;
    logic [ptmw_pkg::FRAME_W-1:0] base;
    ptmw_pkg::map_req_t           req;
    logic                         typed;
    ptmw_pkg::map_rsp_t           rsp;
  } map_case_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  ptmw_pkg::map_req_t           cmd;
  logic                         done;
  ptmw_pkg::map_rsp_t           result;
  logic                         cfg_we;
  logic [ptmw_pkg::FRAME_W-1:0] cfg_data;

  // Shadow copy of the walker's tables, allocator and base register
  logic [ptmw_pkg::ENTRY_W-1:0] shadow_tables [0:POOL*ptmw_pkg::ENTRIES_PER_LEVEL-1];
  int unsigned                  shadow_next_slot;
  logic [ptmw_pkg::FRAME_W-1:0] shadow_base;

  ptmw_pkg::map_rsp_t map_outcomes_q [$];
  ptmw_pkg::map_req_t mapped_pages [$];
  map_case_t          dir_cases [$];
  int unsigned        mismatch_count;
  int unsigned        cycle_count;
  int unsigned        burst_left;

  page_table_map_walker u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Virtual page number from its four level indices
  function automatic logic [ptmw_pkg::VPAGE_W-1:0] page_of(input int unsigned l4,
                                                           input int unsigned l3,
                                                           input int unsigned l2,
                                                           input int unsigned l1);
    return {9'(l4), 9'(l3), 9'(l2), 9'(l1)};
  endfunction

  function automatic logic [8:0] walk_idx(input logic [ptmw_pkg::VPAGE_W-1:0] vp,
                                          input int unsigned depth);
    return 9'(vp >> (27 - 9 * depth));
  endfunction

  // Walk the shadow tables, take new tables as needed and write the leaf
  function automatic ptmw_pkg::map_rsp_t map_page(input ptmw_pkg::map_req_t r);
    int unsigned                  slot;
    int unsigned                  depth;
    int unsigned                  need;
    logic [ptmw_pkg::ENTRY_W-1:0] ent;
    logic [ptmw_pkg::FRAME_W-1:0] offs;
    logic [ptmw_pkg::FRAME_W-1:0] frame;
    logic                         refused;
    ptmw_pkg::map_rsp_t           o;
    slot = r.root_slot;
    depth = 0;
    refused = 1'b0;
    o = '0;
    // existing levels are only read
    while (depth < LAST_DEPTH) begin
      ent = shadow_tables[slot * ptmw_pkg::ENTRIES_PER_LEVEL + walk_idx(r.virt_page, depth)];
      if ((ent & ENTRY_PRESENT) == '0) break;
      offs = ent[51:12] - shadow_base;
      if (offs >= ptmw_pkg::FRAME_W'(POOL)) begin
        refused = 1'b1;
        break;
      end
      slot = int'(offs);
      depth++;
    end
    need = LAST_DEPTH - depth;
    if (!refused && shadow_next_slot + need > POOL) refused = 1'b1;
    if (refused) return REFUSED_RSP;
    // missing levels come from the bump allocator
    while (depth < LAST_DEPTH) begin
      frame = shadow_base + ptmw_pkg::FRAME_W'(shadow_next_slot);
      shadow_tables[slot * ptmw_pkg::ENTRIES_PER_LEVEL + walk_idx(r.virt_page, depth)] =
        {12'h000, frame, ptmw_pkg::TABLE_FLAGS};
      slot = shadow_next_slot;
      shadow_next_slot++;
      depth++;
    end
    o.status = MAP_OK;
    o.leaf_entry = {12'h000, r.phys_frame, 12'h000} | ENTRY_PRESENT | r.leaf_flags;
    o.tables_added = 2'(need);
    o.leaf_table_slot = 6'(slot);
    shadow_tables[slot * ptmw_pkg::ENTRIES_PER_LEVEL + walk_idx(r.virt_page, LAST_DEPTH)] =
      o.leaf_entry;
    return o;
  endfunction

  function automatic map_case_t mk_case(input int unsigned root,
                                        input logic [ptmw_pkg::VPAGE_W-1:0] vp,
                                        input logic [ptmw_pkg::FRAME_W-1:0] phys,
                                        input logic [ptmw_pkg::ENTRY_W-1:0] flags);
    map_case_t c;
    c.set_base = 1'b0;
    c.base = '0;
    c.req = '{root_slot: 2'(root), virt_page: vp, phys_frame: phys, leaf_flags: flags};
    c.typed = 1'b0;
    c.rsp = '0;
    return c;
  endfunction

  function automatic map_case_t typed_case(input int unsigned root,
                                           input logic [ptmw_pkg::VPAGE_W-1:0] vp,
                                           input logic [ptmw_pkg::FRAME_W-1:0] phys,
                                           input logic [ptmw_pkg::ENTRY_W-1:0] flags,
                                           input ptmw_pkg::map_rsp_t rsp);
    map_case_t c;
    c = mk_case(root, vp, phys, flags);
    c.typed = 1'b1;
    c.rsp = rsp;
    return c;
  endfunction

  // Mostly walks along pages already mapped, with some noise
  function automatic ptmw_pkg::map_req_t random_map();
    ptmw_pkg::map_req_t r;
    ptmw_pkg::map_req_t known;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    r.root_slot = 2'($urandom);
    r.virt_page = ptmw_pkg::VPAGE_W'({$urandom, $urandom});
    if (pick >= 10 && mapped_pages.size() != 0) begin
      known = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      r.root_slot = known.root_slot;
      r.virt_page = known.virt_page;
      if (pick < 60) r.virt_page[8:0] = 9'($urandom);
      else if (pick < 72) r.virt_page[17:9] = 9'($urandom);
      else if (pick < 78) r.virt_page[26:18] = 9'($urandom);
    end
    r.phys_frame = ptmw_pkg::FRAME_W'({$urandom, $urandom});
    r.leaf_flags = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // Send one command word in bursts with random gaps
  task automatic send_map(input ptmw_pkg::map_req_t r, input logic typed,
                          input ptmw_pkg::map_rsp_t rsp);
    int unsigned        gap;
    ptmw_pkg::map_rsp_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 12);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    cmd <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge
    pred = map_page(r);
    map_outcomes_q.push_back(typed ? rsp : pred);
    if (pred.status == MAP_OK && mapped_pages.size() < KNOWN_CAP) mapped_pages.push_back(r);
  endtask

  // Hold off until every pending map has reported and the walker is free
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (map_outcomes_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_base(input logic [ptmw_pkg::FRAME_W-1:0] base);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= base;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_base = base;
  endtask

  // Result checker: the receiver never stalls
  always @(posedge clk) begin
    ptmw_pkg::map_rsp_t want;
    if (!rst && done) begin
      if (map_outcomes_q.size() == 0) begin
        mismatch_count++;
        $error("result word with no map pending: %h", result);
      end else begin
        want = map_outcomes_q.pop_front();
        if (result.status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(result.status));
        if (result.leaf_entry !== want.leaf_entry)
          flag_mismatch("leaf_entry", want.leaf_entry, result.leaf_entry);
        if (result.tables_added !== want.tables_added)
          flag_mismatch("tables_added", 64'(want.tables_added), 64'(result.tables_added));
        if (result.leaf_table_slot !== want.leaf_table_slot)
          flag_mismatch("leaf_table_slot", 64'(want.leaf_table_slot),
                        64'(result.leaf_table_slot));
      end
    end
  end

  initial begin
    map_case_t                    c;
    logic [ptmw_pkg::FRAME_W-1:0] phase_base [6];
    int                           i;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    for (i = 0; i < POOL * ptmw_pkg::ENTRIES_PER_LEVEL; i++) shadow_tables[i] = '0;
    shadow_next_slot = ROOTS;
    shadow_base = '0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, one to three new tables, pool running dry,
    // leaf overwrite on a full pool, then a stale pointer after a base move
    c = typed_case(0, page_of(0, 0, 0, 0), '0, '0,
                   '{status: MAP_OK, leaf_entry: 64'h1, tables_added: 2'd3,
                     leaf_table_slot: 6'd6});
    c.set_base = 1'b1;
    c.base = '0;
    dir_cases.push_back(c);
    dir_cases.push_back(typed_case(3, '1, '1, '1,
                        '{status: MAP_OK, leaf_entry: '1, tables_added: 2'd3,
                          leaf_table_slot: 6'd9}));
    dir_cases.push_back(mk_case(0, page_of(0, 0, 1, 5), 40'h12345, 64'h8000_0000_0000_0002));
    dir_cases.push_back(mk_case(0, page_of(0, 1, 0, 0), 40'hAA_AAAA_AAAA,
                                64'h5555_5555_5555_5555));
    // present bit left clear in the flags, upper bits set above the frame
    dir_cases.push_back(mk_case(1, page_of(0, 0, 0, 0), 40'h00_0F0F_0F0F,
                                64'hFFF0_0000_0000_0F06));
    // fill the pool with three new tables per word
    for (i = 0; i < 16; i++)
      dir_cases.push_back(mk_case(i % 4, page_of(16 * (i + 1), i, 2 * i, 3 * i),
                                  ptmw_pkg::FRAME_W'(64'h9E37_79B9_7F4A_7C15 * (i + 1)),
                                  64'h1 << (4 * i)));
    dir_cases.push_back(typed_case(2, page_of(300, 1, 2, 3), 40'h1, 64'h0, REFUSED_RSP));
    dir_cases.push_back(typed_case(0, page_of(0, 0, 2, 0), 40'h2, 64'h0, REFUSED_RSP));
    dir_cases.push_back(typed_case(3, '1, 40'h1, '0,
                        '{status: MAP_OK, leaf_entry: 64'h1001, tables_added: 2'd0,
                          leaf_table_slot: 6'd9}));
    c = typed_case(0, page_of(0, 0, 0, 0), 40'h3, 64'h0, REFUSED_RSP);
    c.set_base = 1'b1;
    c.base = 40'd100;
    dir_cases.push_back(c);

    foreach (dir_cases[k]) begin
      if (dir_cases[k].set_base) begin
        wait_idle();
        write_base(dir_cases[k].base);
      end
      send_map(dir_cases[k].req, dir_cases[k].typed, dir_cases[k].rsp);
    end

    // Random phases, each after a write of its table base
    phase_base = '{40'h0, 40'hFF_FFFF_FFFF, 40'h1, ptmw_pkg::FRAME_W'({$urandom, $urandom}),
                   40'h2, 40'h0};
    foreach (phase_base[p]) begin
      wait_idle();
      write_base(phase_base[p]);
      repeat (RAND_PER_PHASE) begin
        if ($urandom_range(0, 63) == 0) wait_idle();
        send_map(random_map(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
